FILE: src/tva_pkg.sv
// ----------------------------------------------------------------------------
// tva_pkg
// Widths, constants, types and helpers for the thrust-vector-to-attitude path.
// ----------------------------------------------------------------------------
package tva_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FORCE_BITS = 24;
  localparam int CORDIC_N   = 20;

  localparam int IN_W  = ((3 * ANGLE_BITS + 3 * FORCE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * ANGLE_BITS + FORCE_BITS + 7) / 8) * 8;

  // internal angle, 2^-20 rad
  localparam int ZW = 25;
  localparam logic signed [ZW-1:0] PI_U      = 25'sd3294199;
  localparam logic signed [ZW-1:0] HALF_PI_U = 25'sd1647099;
  localparam logic signed [ZW-1:0] TWO_PI_U  = 25'sd6588397;

  // rotation CORDIC, Q1.30
  localparam int SC_W = 33;
  localparam int XW   = 34;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam int SC_LAT = CORDIC_N + 2;

  // products
  localparam int PW    = 68;
  localparam int RXW   = FORCE_BITS + 2;
  localparam int CA_W  = SC_W + 1;
  localparam int PX_W  = FORCE_BITS + SC_W;
  localparam int PT_W  = 2 * SC_W;
  localparam int PM_W  = FORCE_BITS + CA_W;

  // square root
  localparam int SQ_IN_W = 2 * RXW;
  localparam int SQ_RW   = RXW;
  localparam int SQ_LAT  = SQ_RW;

  // vectoring CORDIC
  localparam int AT_IN_W  = RXW + 1;
  localparam int AT_NW    = AT_IN_W + 1;
  localparam int NORM_MSB = 40;
  localparam int AT_CW    = NORM_MSB + 5;
  localparam int AT_LAT   = CORDIC_N + 4;

  localparam logic signed [ANGLE_BITS:0] ANG_MAX = (ANGLE_BITS + 1)'(2 ** (ANGLE_BITS - 1) - 1);
  localparam logic signed [ANGLE_BITS:0] ANG_MIN = -ANG_MAX - 1;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [FORCE_BITS-1:0] force_t;
  typedef logic signed [SC_W-1:0]       sc_t;

  typedef struct packed {
    force_t fx;
    force_t fy;
    force_t fz;
  } fvec_t;

  typedef struct packed {
    logic signed [RXW-1:0] rx;
    logic signed [RXW-1:0] sy;
    force_t                fz;
    logic                  flag;
  } side_t;

  // atan(2^-i), 2^-20 rad
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 25'sd823550;
      1:  v = 25'sd486170;
      2:  v = 25'sd256879;
      3:  v = 25'sd130396;
      4:  v = 25'sd65451;
      5:  v = 25'sd32757;
      6:  v = 25'sd16383;
      7:  v = 25'sd8192;
      8:  v = 25'sd4096;
      9:  v = 25'sd2048;
      10: v = 25'sd1024;
      11: v = 25'sd512;
      12: v = 25'sd256;
      13: v = 25'sd128;
      14: v = 25'sd64;
      15: v = 25'sd32;
      16: v = 25'sd16;
      17: v = 25'sd8;
      18: v = 25'sd4;
      19: v = 25'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round Q1.30 product to integer
  function automatic logic signed [PW-31:0] rnd30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p + PW'(64'sd536870912);
    return q[PW-1:30];
  endfunction

  function automatic logic [5:0] lead_one(input logic [AT_NW-1:0] m);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < AT_NW; i++) begin
      if (m[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  function automatic angle_t out_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] s;
    logic signed [ZW:0] q;
    s = (ZW + 1)'(z) + (ZW + 1)'(64);
    q = s >>> 7;
    if (q > (ZW + 1)'(ANG_MAX)) return ANGLE_BITS'(ANG_MAX);
    if (q < (ZW + 1)'(ANG_MIN)) return ANGLE_BITS'(ANG_MIN);
    return ANGLE_BITS'(q);
  endfunction

endpackage

FILE: src/tva_sincos.sv
// ----------------------------------------------------------------------------
// tva_sincos
// Pipelined rotation CORDIC: one angle in, sin and cos in Q1.30 out.
// ----------------------------------------------------------------------------
module tva_sincos import tva_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  angle_t ang,
  output sc_t    sin_o,
  output sc_t    cos_o
);

  logic signed [ZW-1:0] a_ext, r_wrap, r_fold;
  logic                 fold;

  logic signed [XW-1:0] xs [0:CORDIC_N];
  logic signed [XW-1:0] ys [0:CORDIC_N];
  logic signed [ZW-1:0] zs [0:CORDIC_N];
  logic                 ng [0:CORDIC_N];

  // input range is below 2*pi, a single wrap suffices
  always_comb begin
    a_ext = ZW'(ang) <<< 7;
    r_wrap = a_ext;
    if (a_ext > PI_U) begin
      r_wrap = a_ext - TWO_PI_U;
    end else if (a_ext < -PI_U) begin
      r_wrap = a_ext + TWO_PI_U;
    end
    fold = 1'b0;
    r_fold = r_wrap;
    if (r_wrap > HALF_PI_U) begin
      r_fold = r_wrap - PI_U;
      fold = 1'b1;
    end else if (r_wrap < -HALF_PI_U) begin
      r_fold = r_wrap + PI_U;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= r_fold;
      ng[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_val(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_val(i);
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= SC_W'(ng[CORDIC_N] ? -xs[CORDIC_N] : xs[CORDIC_N]);
      sin_o <= SC_W'(ng[CORDIC_N] ? -ys[CORDIC_N] : ys[CORDIC_N]);
    end
  end

endmodule

FILE: src/tva_isqrt.sv
// ----------------------------------------------------------------------------
// tva_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tva_isqrt import tva_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_IN_W-1:0] v,
  output logic [SQ_RW-1:0]   root_o
);

  logic [SQ_IN_W-1:0] rem [1:SQ_RW];
  logic [SQ_RW-1:0]   rt  [1:SQ_RW];

  for (genvar j = 0; j < SQ_RW; j++) begin : g_st
    localparam int B = SQ_RW - 1 - j;
    logic [SQ_IN_W+1:0] trial;
    logic [SQ_IN_W-1:0] r_in;
    logic [SQ_RW-1:0]   q_in;

    if (j == 0) begin : g_first
      assign r_in = v;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[j];
      assign q_in = rt[j];
    end

    assign trial = ((SQ_IN_W + 2)'(q_in) << (B + 1)) + ((SQ_IN_W + 2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, r_in} >= trial) begin
          rem[j+1] <= r_in - SQ_IN_W'(trial);
          rt[j+1]  <= q_in | (SQ_RW'(1) << B);
        end else begin
          rem[j+1] <= r_in;
          rt[j+1]  <= q_in;
        end
      end
    end
  end

  assign root_o = rt[SQ_RW];

endmodule

FILE: src/tva_atan2.sv
// ----------------------------------------------------------------------------
// tva_atan2
// Pipelined atan2: half-plane fold, normalize, vectoring CORDIC, round to Q3.13.
// ----------------------------------------------------------------------------
module tva_atan2 import tva_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AT_IN_W-1:0] y_in,
  input  logic signed [AT_IN_W-1:0] x_in,
  output angle_t                    ang_o
);

  logic signed [AT_NW-1:0] xn, yn, ay;
  logic signed [ZW-1:0]    z0;
  logic [AT_NW-1:0]        m0;

  logic signed [AT_NW-1:0] x1, y1, x2, y2;
  logic signed [ZW-1:0]    z1, z2;
  logic [AT_NW-1:0]        m1;
  logic [5:0]              sh2;
  logic                    zero2;

  logic signed [AT_CW-1:0] xs [0:CORDIC_N];
  logic signed [AT_CW-1:0] ys [0:CORDIC_N];
  logic signed [ZW-1:0]    zs [0:CORDIC_N];
  logic                    zr [0:CORDIC_N];

  always_comb begin
    xn = AT_NW'(x_in);
    yn = AT_NW'(y_in);
    z0 = '0;
    if (x_in < 0) begin
      xn = -AT_NW'(x_in);
      yn = -AT_NW'(y_in);
      z0 = (y_in >= 0) ? PI_U : -PI_U;
    end
    ay = (yn < 0) ? -yn : yn;
    m0 = (xn > ay) ? xn : ay;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= xn;
      y1 <= yn;
      z1 <= z0;
      m1 <= m0;
      x2 <= x1;
      y2 <= y1;
      z2 <= z1;
      sh2 <= 6'(NORM_MSB) - lead_one(m1);
      zero2 <= (m1 == '0);
      xs[0] <= AT_CW'(x2) <<< sh2;
      ys[0] <= AT_CW'(y2) <<< sh2;
      zs[0] <= z2;
      zr[0] <= zero2;
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_val(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_val(i);
        end
        zr[i+1] <= zr[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_o <= zr[CORDIC_N] ? '0 : out_angle(zs[CORDIC_N]);
    end
  end

endmodule

FILE: src/thrust_vector_to_attitude.sv
// ----------------------------------------------------------------------------
// thrust_vector_to_attitude
// Thrust setpoint and current attitude to roll/pitch command and body thrust.
//
//   port    dir  dir-of-word  contents (low bit first)
//   s_*     in   upstream     roll_now, pitch_now, yaw_now, force_x/y/z
//   m_*     out  downstream   tdata: roll_cmd, pitch_cmd, body_thrust
//                             tuser: level_fallback
//
// One word per cycle while the output is not stalled; the path runs sin/cos CORDIC,
// product stages, square root and atan2 CORDIC in series.
// Synchronous reset clears only the valid pipeline.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module thrust_vector_to_attitude import tva_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // roll_now, pitch_now, yaw_now, force_x, force_y, force_z
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // roll_cmd, pitch_cmd, body_thrust
  output logic             m_tuser   // level_fallback
);

  localparam int ST_SC   = SC_LAT;
  localparam int ST_P2   = ST_SC + 2;
  localparam int ST_P4   = ST_SC + 4;
  localparam int ST_P6   = ST_SC + 6;
  localparam int ST_SQ   = ST_P4 + SQ_LAT;
  localparam int ST_AT   = ST_SQ + AT_LAT;
  localparam int OUT_LAT = ST_AT + 1;
  localparam int FD_LEN  = ST_SC + 4;
  localparam int SIDE_D  = ST_SQ - ST_P2;
  localparam int TH_D    = ST_AT - ST_P6;

  localparam int A = ANGLE_BITS;
  localparam int F = FORCE_BITS;

  logic en;
  logic [OUT_LAT-1:0] vld;

  angle_t roll_now, pitch_now, yaw_now;
  fvec_t  fin;
  sc_t    sr, cr, sp, cp, syw, cyw;

  fvec_t fd [0:FD_LEN-1];

  logic signed [PX_W-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [PT_W-1:0] p_crsp, p_srsy, p_srcy, p_crcp;
  sc_t                    cy23, sy23, cy24, sy24;

  side_t                  side24;
  sc_t                    t24, rs24, rc24, cc24;

  logic signed [PT_W-1:0] q_tc, q_ts;
  sc_t                    rs25, rc25, cc25;
  logic [SQ_IN_W-1:0]     sq_rx, sq_fz;

  logic signed [CA_W-1:0] ca26, cb26;
  sc_t                    cc26;
  logic [SQ_IN_W-1:0]     sqsum;

  logic signed [PM_W-1:0] m_x, m_y, m_z;
  force_t                 thr28;
  logic signed [PW-31:0]  thr_r;

  logic [SQ_RW-1:0]       mag;
  side_t                  sd [0:SIDE_D-1];
  logic                   fl [0:AT_LAT-1];
  force_t                 td [0:TH_D-1];
  angle_t                 roll_at, pitch_at;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[OUT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[OUT_LAT-2:0], s_tvalid};
    end
  end

  assign roll_now  = s_tdata[A-1:0];
  assign pitch_now = s_tdata[2*A-1:A];
  assign yaw_now   = s_tdata[3*A-1:2*A];
  assign fin.fx    = s_tdata[3*A+F-1:3*A];
  assign fin.fy    = s_tdata[3*A+2*F-1:3*A+F];
  assign fin.fz    = s_tdata[3*A+3*F-1:3*A+2*F];

  tva_sincos u_sc_roll  (.clk(clk), .en(en), .ang(roll_now),  .sin_o(sr),  .cos_o(cr));
  tva_sincos u_sc_pitch (.clk(clk), .en(en), .ang(pitch_now), .sin_o(sp),  .cos_o(cp));
  tva_sincos u_sc_yaw   (.clk(clk), .en(en), .ang(yaw_now),   .sin_o(syw), .cos_o(cyw));

  always_ff @(posedge clk) begin
    if (en) begin
      fd[0] <= fin;
      for (int k = 1; k < FD_LEN; k++) begin
        fd[k] <= fd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      p_xc   <= PX_W'(fd[ST_SC-1].fx) * PX_W'(cyw);
      p_ys   <= PX_W'(fd[ST_SC-1].fy) * PX_W'(syw);
      p_xs   <= PX_W'(fd[ST_SC-1].fx) * PX_W'(syw);
      p_yc   <= PX_W'(fd[ST_SC-1].fy) * PX_W'(cyw);
      p_crsp <= PT_W'(cr) * PT_W'(sp);
      p_srsy <= PT_W'(sr) * PT_W'(syw);
      p_srcy <= PT_W'(sr) * PT_W'(cyw);
      p_crcp <= PT_W'(cr) * PT_W'(cp);
      cy23   <= cyw;
      sy23   <= syw;

      // yaw rotation and matrix terms
      side24.rx   <= RXW'(rnd30(PW'(p_xc) + PW'(p_ys)));
      side24.sy   <= RXW'(rnd30(PW'(p_xs) - PW'(p_yc)));
      side24.fz   <= fd[ST_SC].fz;
      side24.flag <= (fd[ST_SC].fz == '0);
      t24  <= SC_W'(rnd30(PW'(p_crsp)));
      rs24 <= SC_W'(rnd30(PW'(p_srsy)));
      rc24 <= SC_W'(rnd30(PW'(p_srcy)));
      cc24 <= SC_W'(rnd30(PW'(p_crcp)));
      cy24 <= cy23;
      sy24 <= sy23;

      q_tc  <= PT_W'(t24) * PT_W'(cy24);
      q_ts  <= PT_W'(t24) * PT_W'(sy24);
      rs25  <= rs24;
      rc25  <= rc24;
      cc25  <= cc24;
      sq_rx <= SQ_IN_W'(SQ_IN_W'(side24.rx) * SQ_IN_W'(side24.rx));
      sq_fz <= SQ_IN_W'(SQ_IN_W'(side24.fz) * SQ_IN_W'(side24.fz));

      ca26  <= CA_W'(rnd30(PW'(q_tc))) + CA_W'(rs25);
      cb26  <= CA_W'(rnd30(PW'(q_ts))) - CA_W'(rc25);
      cc26  <= cc25;
      sqsum <= sq_rx + sq_fz;

      m_x <= PM_W'(fd[ST_SC+3].fx) * PM_W'(ca26);
      m_y <= PM_W'(fd[ST_SC+3].fy) * PM_W'(cb26);
      m_z <= PM_W'(fd[ST_SC+3].fz) * PM_W'(cc26);

      thr28 <= (thr_r > (PW - 30)'(2 ** (F - 1) - 1)) ? {1'b0, {(F - 1){1'b1}}} :
               (thr_r < -(PW - 30)'(2 ** (F - 1))) ? {1'b1, {(F - 1){1'b0}}} :
               F'(thr_r);
    end
  end

  assign thr_r = rnd30(PW'(m_x) + PW'(m_y) + PW'(m_z));

  tva_isqrt u_sqrt (.clk(clk), .en(en), .v(sqsum), .root_o(mag));

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side24;
      for (int k = 1; k < SIDE_D; k++) begin
        sd[k] <= sd[k-1];
      end
      fl[0] <= sd[SIDE_D-1].flag;
      for (int k = 1; k < AT_LAT; k++) begin
        fl[k] <= fl[k-1];
      end
      td[0] <= thr28;
      for (int k = 1; k < TH_D; k++) begin
        td[k] <= td[k-1];
      end
    end
  end

  tva_atan2 u_pitch (
    .clk(clk), .en(en),
    .y_in(AT_IN_W'(sd[SIDE_D-1].rx)),
    .x_in(AT_IN_W'(sd[SIDE_D-1].fz)),
    .ang_o(pitch_at)
  );

  tva_atan2 u_roll (
    .clk(clk), .en(en),
    .y_in(AT_IN_W'(sd[SIDE_D-1].sy)),
    .x_in(signed'(AT_IN_W'({1'b0, mag}))),
    .ang_o(roll_at)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {td[TH_D-1], (fl[AT_LAT-1] ? '0 : pitch_at), (fl[AT_LAT-1] ? '0 : roll_at)};
      m_tuser <= fl[AT_LAT-1];
    end
  end

endmodule
